[rtl/pending_packet_buffer_by_destination_core_macros.svh]
// Assertion macros used by the verification files of the pending packet buffer.
// The macros expect a signal named clk, and PPBD_ASSERT also rst_n, in the scope where used.
`ifndef PENDING_PACKET_BUFFER_BY_DESTINATION_CORE_MACROS_SVH
`define PENDING_PACKET_BUFFER_BY_DESTINATION_CORE_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define PPBD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must also hold while reset is asserted.
`define PPBD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ppbd_pkg.sv]
// Shared types and constants of the pending packet buffer.
// Used by the top level and the port checker.
`default_nettype none

package ppbd_pkg;

    localparam int CAPACITY    = 32;
    localparam int HANDLE_BITS = 16;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        CMD_ADD          = 2'd0,
        CMD_FLUSH_EXACT  = 2'd1,
        CMD_FLUSH_MASKED = 2'd2,
        CMD_DROP_EXACT   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STATUS_ADDED        = 3'd0,
        STATUS_REJECTED     = 3'd1,
        STATUS_SEND         = 3'd2,
        STATUS_RETURN_ERROR = 3'd3,
        STATUS_NO_MATCH     = 3'd4
    } status_t;

    typedef struct packed {
        logic [1:0]             cmd;
        logic [31:0]            dest_address;
        logic [31:0]            net_mask;
        logic [HANDLE_BITS-1:0] packet_handle;
    } in_word_t;

    typedef struct packed {
        logic [2:0]             status;
        logic [HANDLE_BITS-1:0] out_handle;
        logic [31:0]            send_delay;
        logic                   last;
    } out_word_t;

    typedef struct packed {
        logic [31:0]            dest;
        logic [HANDLE_BITS-1:0] handle;
    } entry_t;

endpackage

`default_nettype wire

[rtl/pending_packet_buffer_by_destination_core.sv]
// Top level of the pending packet buffer: control sequencer and output register.
// Depends on ppbd_pkg and ppbd_ram.
//
// Packets wait in an entry memory kept packed in arrival order, up to CAPACITY deep.
// An add, or a flush or drop on an empty buffer, yields one output word.
// A flush or drop over N held entries scans them one entry per cycle through
// the single read port of the entry memory, except while the output side stalls;
// matches leave in arrival order and survivors are written back compacted.
// No new input word is taken while a flush or drop is in progress.
`default_nettype none

module pending_packet_buffer_by_destination_core
    import ppbd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cfg_write_en,
    input  wire logic [15:0] cfg_write_data,
    input  wire logic      in_valid,
    output logic           in_stall,
    input  wire in_word_t  in_word,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_word_t      out_word
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t      state_reg, state_next;
    logic [15:0] step_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] kept_reg, kept_next;
    logic [31:0] acc_reg, acc_next;
    logic        pend_valid_reg, pend_valid_next;
    out_word_t   pend_reg, pend_next;
    logic        op_drop_reg, op_drop_next;
    logic [31:0] key_reg, key_next;
    logic [31:0] mask_reg, mask_next;
    logic        out_valid_reg;
    out_word_t   out_reg, out_next;
    logic        out_load;

    logic             ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    entry_t           ram_wdata, ram_rdata;

    logic        out_free, accept, match, last_entry;
    logic [32:0] acc_sum;

    ppbd_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk    (clk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (ram_re),
        .rd_addr(ram_raddr),
        .rd_data(ram_rdata)
    );

    assign out_free   = !out_valid_reg || !out_stall;
    assign in_stall   = !((state_reg == ST_IDLE) && out_free);
    assign accept     = in_valid && !in_stall;
    assign out_valid  = out_valid_reg;
    assign out_word   = out_reg;
    assign match      = ((ram_rdata.dest ^ key_reg) & mask_reg) == 32'd0;
    assign last_entry = {1'b0, idx_reg} == (count_reg - CNT_W'(1));
    assign acc_sum    = {1'b0, acc_reg} + {17'd0, step_reg};

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        kept_next       = kept_reg;
        acc_next        = acc_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        op_drop_next    = op_drop_reg;
        key_next        = key_reg;
        mask_next       = mask_reg;
        out_load        = 1'b0;
        out_next        = out_reg;
        ram_we          = 1'b0;
        ram_waddr       = kept_reg[IDX_W-1:0];
        ram_wdata       = ram_rdata;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (in_word.cmd == CMD_ADD)
                    begin
                        out_load            = 1'b1;
                        out_next.out_handle = in_word.packet_handle;
                        out_next.send_delay = 32'd0;
                        out_next.last       = 1'b1;
                        if (count_reg == CNT_W'(CAPACITY))
                        begin
                            out_next.status = STATUS_REJECTED;
                        end
                        else
                        begin
                            out_next.status  = STATUS_ADDED;
                            ram_we           = 1'b1;
                            ram_waddr        = count_reg[IDX_W-1:0];
                            ram_wdata.dest   = in_word.dest_address;
                            ram_wdata.handle = in_word.packet_handle;
                            count_next       = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        out_load            = 1'b1;
                        out_next.status     = STATUS_NO_MATCH;
                        out_next.out_handle = '0;
                        out_next.send_delay = 32'd0;
                        out_next.last       = 1'b1;
                    end
                    else
                    begin
                        key_next        = in_word.dest_address;
                        mask_next       = (in_word.cmd == CMD_FLUSH_MASKED) ?
                                          in_word.net_mask : 32'hFFFF_FFFF;
                        op_drop_next    = in_word.cmd == CMD_DROP_EXACT;
                        ram_re          = 1'b1;
                        ram_raddr       = '0;
                        idx_next        = '0;
                        kept_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!match || !pend_valid_reg || out_free)
                begin
                    if (match)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_load = 1'b1;
                            out_next = pend_reg;
                        end
                        pend_valid_next      = 1'b1;
                        pend_next.out_handle = ram_rdata.handle;
                        pend_next.last       = 1'b0;
                        if (op_drop_reg)
                        begin
                            pend_next.status     = STATUS_RETURN_ERROR;
                            pend_next.send_delay = 32'd0;
                        end
                        else
                        begin
                            pend_next.status     = STATUS_SEND;
                            pend_next.send_delay = acc_reg;
                            acc_next = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
                        end
                    end
                    else
                    begin
                        ram_we    = 1'b1;
                        kept_next = kept_reg + CNT_W'(1);
                    end
                    if (last_entry)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + IDX_W'(1);
                        idx_next  = idx_reg + IDX_W'(1);
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_free)
                begin
                    out_load = 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_next      = pend_reg;
                        out_next.last = 1'b1;
                    end
                    else
                    begin
                        out_next.status     = STATUS_NO_MATCH;
                        out_next.out_handle = '0;
                        out_next.send_delay = 32'd0;
                        out_next.last       = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    count_next      = kept_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            step_reg       <= 16'd10;
            count_reg      <= '0;
            idx_reg        <= '0;
            kept_reg       <= '0;
            acc_reg        <= 32'd0;
            pend_valid_reg <= 1'b0;
            op_drop_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            kept_reg       <= kept_next;
            acc_reg        <= acc_next;
            pend_valid_reg <= pend_valid_next;
            op_drop_reg    <= op_drop_next;
            if (cfg_write_en)
            begin
                step_reg <= cfg_write_data;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        key_reg  <= key_next;
        mask_reg <= mask_next;
        out_reg  <= out_next;
    end

endmodule

`default_nettype wire

[rtl/ppbd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing; used by the pending packet buffer for its entry store.
`default_nettype none

module ppbd_ram #(
    parameter int WIDTH  = 48,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/ppbd_checker.sv]
// Port-level assertions for the pending packet buffer, bound to its top level.
// Depends on ppbd_pkg and the assertion macro header.
`default_nettype none

`include "pending_packet_buffer_by_destination_core_macros.svh"

module ppbd_port_checks
    import ppbd_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      in_valid,
    input wire logic      in_stall,
    input wire in_word_t  in_word,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_word_t out_word
);

    `PPBD_ASSERT(a_out_hold,
        out_valid && out_stall |=> out_valid && $stable(out_word),
        "stalled output word changed")
    `PPBD_ASSERT(a_no_match_form,
        out_valid && out_word.status == STATUS_NO_MATCH |->
            out_word.last && out_word.out_handle == '0 && out_word.send_delay == 32'd0,
        "malformed no-match word")
    `PPBD_ASSERT(a_add_single,
        out_valid && (out_word.status == STATUS_ADDED || out_word.status == STATUS_REJECTED)
            |-> out_word.last && out_word.send_delay == 32'd0,
        "add result not a single final word")
    `PPBD_ASSERT(a_add_in_result,
        in_valid && !in_stall && in_word.cmd == CMD_ADD |=>
            out_valid && out_word.out_handle == $past(in_word.packet_handle),
        "add result did not follow its input word")
    `PPBD_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !out_valid, "output valid during reset")

endmodule

bind pending_packet_buffer_by_destination_core ppbd_port_checks u_ppbd_checker (.*);

`default_nettype wire
